// File: rtl/msb_first_bit_packer_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bit packer core
// Shared property forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_PACKER_CORE_ASSERT_SVH
`define MSB_FIRST_BIT_PACKER_CORE_ASSERT_SVH

// same-cycle implication
`define MFBP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MFBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mfbp_pkg.sv
// ---------------------------------------------------------------------------
// mfbp_pkg
// Types and constants shared by the bit packer front end, queue and back end.
// ---------------------------------------------------------------------------
`default_nettype none

package mfbp_pkg;

  localparam int VAL_W  = 64;
  localparam int CNT_W  = 7;
  localparam int LEN_W  = 9;
  localparam int CMD_W  = 3;
  localparam int BYTE_W = 8;

  localparam logic [CNT_W-1:0] MAX_BITS  = 7'd64;
  localparam logic [CNT_W-1:0] BYTE_BITS = 7'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 3'd0,
    CMD_LOAD  = 3'd1,
    CMD_PUT   = 3'd2,
    CMD_GET   = 3'd3,
    CMD_FETCH = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_WRONG_MODE = 2'd1,
    ST_BEYOND     = 2'd2
  } status_t;

  // store operation handed to the back end
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_CLEAR = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_FETCH = 3'd4
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [CNT_W-1:0] n;
    logic [VAL_W-1:0] value;
    status_t          status;
    logic [LEN_W-1:0] length;
  } job_t;

endpackage

`default_nettype wire

// File: rtl/mfbp_ram.sv
// ---------------------------------------------------------------------------
// mfbp_ram
// Generic single write port RAM with one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module mfbp_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/mfbp_fifo.sv
// ---------------------------------------------------------------------------
// mfbp_fifo
// Two-entry queue between the front end and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module mfbp_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

// File: rtl/mfbp_front.sv
// ---------------------------------------------------------------------------
// mfbp_front
// Takes words, keeps mode, cursor and end mark, and queues store jobs.
// ---------------------------------------------------------------------------
`default_nettype none

module mfbp_front #(
  parameter  int BUF_BYTES = 256,
  localparam int BUF_BITS  = BUF_BYTES * 8,
  localparam int CW        = $clog2(BUF_BITS + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mfbp_pkg::CMD_W-1:0]     command,
  input  logic [mfbp_pkg::CNT_W-1:0]     bit_count,
  input  logic [mfbp_pkg::VAL_W-1:0]     put_value,
  input  logic [mfbp_pkg::BYTE_W-1:0]    load_data,
  input  logic [mfbp_pkg::BYTE_W-1:0]    byte_index,
  input  logic                           fifo_full,
  output logic                           push,
  output mfbp_pkg::job_t                 job,
  output logic [CW-1:0]                  job_pos
);

  import mfbp_pkg::*;

  logic          unpack_mode;
  logic [CW-1:0] cursor_bit;
  logic [CW-1:0] cursor_bit_next;
  logic [CW-1:0] end_bit;
  logic [CW-1:0] end_bit_next;

  logic [CNT_W-1:0] n_sat;
  logic [CW:0]      sum_bits;
  logic             fits;
  logic [CW-3:0]    used;
  logic [CW-3:0]    used_next;
  logic [CW-1:0]    load_pos;

  assign in_ready = ~fifo_full;
  assign push     = in_valid & ~fifo_full;

  always_comb begin
    n_sat     = (bit_count > MAX_BITS) ? MAX_BITS : bit_count;
    sum_bits  = {1'b0, cursor_bit} + (CW+1)'(n_sat);
    fits      = (sum_bits <= (CW+1)'(BUF_BITS));
    used      = (CW-2)'(({1'b0, end_bit} + (CW+1)'(7)) >> 3);
    load_pos  = CW'({used, 3'b000});

    cursor_bit_next = cursor_bit;
    end_bit_next    = end_bit;
    job.op          = OP_NONE;
    job.n           = n_sat;
    job.value       = put_value;
    job.status      = ST_OK;
    job_pos         = cursor_bit;

    unique case (cmd_t'(command))
      CMD_CLEAR: begin
        job.op          = OP_CLEAR;
        cursor_bit_next = '0;
        end_bit_next    = '0;
      end
      CMD_LOAD: begin
        if (!unpack_mode) begin
          job.status = ST_WRONG_MODE;
        end else if (int'(used) >= BUF_BYTES) begin
          job.status = ST_BEYOND;
        end else begin
          // a load is a byte-aligned eight-bit write at the end mark
          job.op       = OP_WRITE;
          job.n        = BYTE_BITS;
          job.value    = VAL_W'(load_data);
          job_pos      = load_pos;
          end_bit_next = load_pos + CW'(8);
        end
      end
      CMD_PUT: begin
        if (unpack_mode) begin
          job.status = ST_WRONG_MODE;
        end else if (!fits) begin
          job.status = ST_BEYOND;
        end else begin
          job.op          = (n_sat == '0) ? OP_NONE : OP_WRITE;
          cursor_bit_next = sum_bits[CW-1:0];
          if (end_bit < sum_bits[CW-1:0]) begin
            end_bit_next = sum_bits[CW-1:0];
          end
        end
      end
      CMD_GET: begin
        if (!unpack_mode) begin
          job.status = ST_WRONG_MODE;
        end else if (!fits) begin
          job.status = ST_BEYOND;
        end else begin
          job.op          = (n_sat == '0) ? OP_NONE : OP_READ;
          cursor_bit_next = sum_bits[CW-1:0];
        end
      end
      CMD_FETCH: begin
        if (int'(byte_index) >= BUF_BYTES) begin
          job.status = ST_BEYOND;
        end else begin
          job.op  = OP_FETCH;
          job.n   = BYTE_BITS;
          job_pos = CW'({byte_index, 3'b000});
        end
      end
      default: begin
      end
    endcase

    used_next  = (CW-2)'(({1'b0, end_bit_next} + (CW+1)'(7)) >> 3);
    job.length = LEN_W'(used_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unpack_mode <= 1'b0;
      cursor_bit  <= '0;
      end_bit     <= '0;
    end else begin
      if (cfg_wr_en) begin
        unpack_mode <= cfg_wr_data;
      end
      if (push) begin
        cursor_bit <= cursor_bit_next;
        end_bit    <= end_bit_next;
      end
    end
  end

`include "msb_first_bit_packer_core_assert.svh"

  `MFBP_ASSERT_IMPL(a_bits_in_store, 1'b1, (cursor_bit <= CW'(BUF_BITS)) && (end_bit <= CW'(BUF_BITS)), "bit position beyond store")

endmodule

`default_nettype wire

// File: rtl/mfbp_back.sv
// ---------------------------------------------------------------------------
// mfbp_back
// Runs store jobs on two banks of 64-bit rows and holds the result word.
// ---------------------------------------------------------------------------
`default_nettype none

module mfbp_back #(
  parameter  int BUF_BYTES = 256,
  localparam int BUF_BITS  = BUF_BYTES * 8,
  localparam int CW        = $clog2(BUF_BITS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        job_valid,
  output logic                        pop,
  input  mfbp_pkg::job_t              head,
  input  logic [CW-1:0]               head_pos,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mfbp_pkg::VAL_W-1:0]  got_value,
  output logic [mfbp_pkg::BYTE_W-1:0] byte_out,
  output logic [mfbp_pkg::LEN_W-1:0]  length_bytes,
  output logic [1:0]                  status
);

  import mfbp_pkg::*;

  // rows of 8 bytes, even rows in bank 0, odd rows in bank 1
  localparam int NROWS  = (BUF_BYTES + 7) / 8;
  localparam int BDEPTH = (NROWS + 1) / 2;
  localparam int AW     = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int RW     = CW - 6;

  typedef enum logic [3:0] {
    S_SWEEP  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_ACCESS = 4'b0100,
    S_HOLD   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [AW-1:0] sweep_addr;
  logic          sweep_cmd;
  logic          sweep_last;

  job_t          cur;
  logic [CW-1:0] cur_pos;
  logic [VAL_W-1:0]  res_got;
  logic [BYTE_W-1:0] res_byte;

  logic              out_free;
  logic              emit;
  logic              emit_head;
  logic              hold_load;
  logic [VAL_W-1:0]  val_got;
  logic [BYTE_W-1:0] val_byte;
  job_t              emit_job;

  logic [AW-1:0]    raddr0;
  logic [AW-1:0]    raddr1;
  logic [AW-1:0]    waddr0;
  logic [AW-1:0]    waddr1;
  logic             we0;
  logic             we1;
  logic [VAL_W-1:0] wdata0;
  logic [VAL_W-1:0] wdata1;
  logic [VAL_W-1:0] rdata0;
  logic [VAL_W-1:0] rdata1;

  logic [RW-1:0]    row;
  logic [5:0]       off;
  logic [RW:0]      row_inc;
  logic             lower_ok;
  logic [VAL_W-1:0] upper;
  logic [VAL_W-1:0] lower;
  logic [VAL_W-1:0] nmask;
  logic [7:0]       shamt;
  logic [127:0]     win;
  logic [127:0]     wmask;
  logic [127:0]     wbits;
  logic [127:0]     merged;
  logic [VAL_W-1:0] field;
  logic             wr_job;

  function automatic logic [AW-1:0] bank0_addr(input logic [RW-1:0] r);
    logic [RW:0] inc;
    inc        = {1'b0, r} + (RW+1)'(1);
    bank0_addr = AW'(inc >> 1);
  endfunction

  function automatic logic [AW-1:0] bank1_addr(input logic [RW-1:0] r);
    bank1_addr = AW'(r >> 1);
  endfunction

  function automatic logic [VAL_W-1:0] low_mask(input logic [CNT_W-1:0] n);
    low_mask = n[6] ? '1 : ((VAL_W'(1) << n[5:0]) - VAL_W'(1));
  endfunction

  mfbp_ram #(.WIDTH(VAL_W), .DEPTH(BDEPTH)) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr0),
    .wdata (wdata0),
    .raddr (raddr0),
    .rdata (rdata0)
  );

  mfbp_ram #(.WIDTH(VAL_W), .DEPTH(BDEPTH)) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr1),
    .wdata (wdata1),
    .raddr (raddr1),
    .rdata (rdata1)
  );

  assign raddr0 = bank0_addr(head_pos[CW-1:6]);
  assign raddr1 = bank1_addr(head_pos[CW-1:6]);

  // two-row window around the field, merge for writes, extract for reads
  always_comb begin
    row      = cur_pos[CW-1:6];
    off      = cur_pos[5:0];
    row_inc  = {1'b0, row} + (RW+1)'(1);
    lower_ok = ((row_inc >> 1) < (RW+1)'(BDEPTH));
    upper    = row[0] ? rdata1 : rdata0;
    lower    = row[0] ? rdata0 : rdata1;
    win      = {upper, lower};
    nmask    = low_mask(cur.n);
    shamt    = 8'd128 - {2'b00, off} - {1'b0, cur.n};
    wmask    = {64'd0, nmask} << shamt;
    wbits    = {64'd0, cur.value & nmask} << shamt;
    merged   = (win & ~wmask) | wbits;
    field    = VAL_W'(win >> shamt) & nmask;
  end

  assign wr_job     = (state == S_ACCESS) && (cur.op == OP_WRITE);
  assign sweep_last = (sweep_addr == AW'(BDEPTH - 1));

  always_comb begin
    if (state == S_SWEEP) begin
      we0    = 1'b1;
      we1    = 1'b1;
      waddr0 = sweep_addr;
      waddr1 = sweep_addr;
      wdata0 = '0;
      wdata1 = '0;
    end else begin
      we0    = wr_job && (!row[0] || lower_ok);
      we1    = wr_job;
      waddr0 = bank0_addr(row);
      waddr1 = bank1_addr(row);
      wdata0 = row[0] ? merged[63:0] : merged[127:64];
      wdata1 = row[0] ? merged[127:64] : merged[63:0];
    end
  end

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    emit       = 1'b0;
    emit_head  = 1'b0;
    hold_load  = 1'b0;
    val_got    = '0;
    val_byte   = '0;

    unique case (state)
      S_SWEEP: begin
        if (sweep_last) begin
          if (!sweep_cmd) begin
            state_next = S_IDLE;
          end else if (out_free) begin
            emit       = 1'b1;
            state_next = S_IDLE;
          end else begin
            hold_load  = 1'b1;
            state_next = S_HOLD;
          end
        end
      end
      S_IDLE: begin
        if (job_valid) begin
          pop = 1'b1;
          unique case (head.op)
            OP_NONE: begin
              if (out_free) begin
                emit      = 1'b1;
                emit_head = 1'b1;
              end else begin
                hold_load  = 1'b1;
                state_next = S_HOLD;
              end
            end
            OP_CLEAR: state_next = S_SWEEP;
            default:  state_next = S_ACCESS;
          endcase
        end
      end
      S_ACCESS: begin
        if (cur.op == OP_READ) begin
          val_got = field;
        end
        if (cur.op == OP_FETCH) begin
          val_byte = field[BYTE_W-1:0];
        end
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end else begin
          hold_load  = 1'b1;
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        val_got  = res_got;
        val_byte = res_byte;
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign emit_job = emit_head ? head : cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_addr <= '0;
      sweep_cmd  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SWEEP) begin
        sweep_addr <= sweep_addr + AW'(1);
      end
      if (pop && (head.op == OP_CLEAR)) begin
        sweep_addr <= '0;
        sweep_cmd  <= 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur     <= head;
      cur_pos <= head_pos;
    end
    if (hold_load) begin
      res_got  <= val_got;
      res_byte <= val_byte;
    end
    if (emit) begin
      got_value    <= val_got;
      byte_out     <= val_byte;
      length_bytes <= emit_job.length;
      status       <= emit_job.status;
    end
  end

`include "msb_first_bit_packer_core_assert.svh"

  `MFBP_ASSERT_IMPL(a_access_op, state == S_ACCESS, cur.op == OP_WRITE || cur.op == OP_READ || cur.op == OP_FETCH, "access state without a store job")
  `MFBP_ASSERT_IMPL(a_emit_free, emit, !out_valid || out_ready, "result word overwritten")
  `MFBP_ASSERT_IMPL(a_store_write, we0 || we1, state == S_ACCESS || state == S_SWEEP, "store written outside access or sweep")
  `MFBP_ASSERT_NEXT(a_clear_sweeps, pop && head.op == OP_CLEAR, state == S_SWEEP && sweep_addr == '0, "clear did not start a sweep")

endmodule

`default_nettype wire

// File: rtl/msb_first_bit_packer_core.sv
// ---------------------------------------------------------------------------
// msb_first_bit_packer_core
// MSB-first bit field packer and unpacker over a byte store.
// ---------------------------------------------------------------------------
//  channel  | handshake               | word
//  ---------+-------------------------+-------------------------------------------
//  cfg      | cfg_wr_en               | cfg_wr_data (unpack mode)
//  in       | in_valid / in_ready     | command, bit_count, put_value, load_data,
//           |                         | byte_index
//  out      | out_valid / out_ready   | got_value, byte_out, length_bytes, status
//
//  Load, put, get and fetch run in the back end as a registered read of both
//  row banks, then a merge and write-back.
//  A clear, and reset, sweep every row of both banks to zero;
//  input words queue up meanwhile.
//  A two-entry queue lets the front end take words while a result is stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module msb_first_bit_packer_core #(
  parameter int BUF_BYTES = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mfbp_pkg::CMD_W-1:0]  command,
  input  logic [mfbp_pkg::CNT_W-1:0]  bit_count,
  input  logic [mfbp_pkg::VAL_W-1:0]  put_value,
  input  logic [mfbp_pkg::BYTE_W-1:0] load_data,
  input  logic [mfbp_pkg::BYTE_W-1:0] byte_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mfbp_pkg::VAL_W-1:0]  got_value,
  output logic [mfbp_pkg::BYTE_W-1:0] byte_out,
  output logic [mfbp_pkg::LEN_W-1:0]  length_bytes,
  output logic [1:0]                  status
);

  import mfbp_pkg::*;

  localparam int BUF_BITS = BUF_BYTES * 8;
  localparam int CW       = $clog2(BUF_BITS + 1);
  localparam int QW       = $bits(job_t) + CW;

  logic          push;
  logic          fifo_full;
  job_t          push_job;
  logic [CW-1:0] push_pos;
  logic [QW-1:0] q_in;
  logic [QW-1:0] q_out;
  logic          q_valid;
  logic          q_pop;
  job_t          head;
  logic [CW-1:0] head_pos;

  mfbp_front #(.BUF_BYTES(BUF_BYTES)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .bit_count   (bit_count),
    .put_value   (put_value),
    .load_data   (load_data),
    .byte_index  (byte_index),
    .fifo_full   (fifo_full),
    .push        (push),
    .job         (push_job),
    .job_pos     (push_pos)
  );

  assign q_in = {push_pos, push_job};

  mfbp_fifo #(.WIDTH(QW)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (q_in),
    .full      (fifo_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_valid)
  );

  assign head     = job_t'(q_out[$bits(job_t)-1:0]);
  assign head_pos = q_out[QW-1:$bits(job_t)];

  mfbp_back #(.BUF_BYTES(BUF_BYTES)) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (q_valid),
    .pop          (q_pop),
    .head         (head),
    .head_pos     (head_pos),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .got_value    (got_value),
    .byte_out     (byte_out),
    .length_bytes (length_bytes),
    .status       (status)
  );

endmodule

`default_nettype wire
